// File: sv/etf_pkg.sv
// Shared types, constants and helpers for the escape-time fractal pixel block.
package etf_pkg;

    // Number format and field widths
    localparam int VAL_W      = 48;
    localparam int HALF_W     = VAL_W / 2;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int MAG_W      = 47;
    localparam int COUNT_W    = 16;
    localparam int LIMIT_W    = 7;
    localparam int COORD_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 64;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [MAG_W-1:0]        MAG_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTAL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SCALE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM       = 3'd7;

    typedef struct packed {
        logic                      fractal_mode;
        logic [COUNT_W-1:0]        max_iterations;
        logic [LIMIT_W-1:0]        escape_limit;
        logic signed [VAL_W-1:0]   center_re;
        logic signed [VAL_W-1:0]   center_im;
        logic [MAG_W-1:0]          pixel_scale;
        logic signed [VAL_W-1:0]   julia_re;
        logic signed [VAL_W-1:0]   julia_im;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fractal_mode:   1'b0,
        max_iterations: 16'd100,
        escape_limit:   7'd16,
        center_re:      -48'sd549755813888,
        center_im:      48'sd0,
        pixel_scale:    47'd1099511628,
        julia_re:       48'sd0,
        julia_im:       48'sd0
    };

    // Multiplier lane steps
    typedef struct packed {
        logic mul_lo;
        logic mul_hi;
        logic mul_acc;
        logic mul_fin;
    } mul_cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic     map_mul;
        logic     map_add;
        mul_cmd_t mul;
        logic     update;
        logic     root_start;
        logic     load_out;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic at_max;
        logic escaped;
        logic root_busy;
    } dp_status_t;

    // Clamp a two-bit-wider sum back into the value range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [VAL_W+1:0] v);
        logic signed [VAL_W+1:0] hi_lim;
        logic signed [VAL_W+1:0] lo_lim;
        hi_lim = {2'b00, VAL_MAX};
        lo_lim = {2'b11, VAL_MIN};
        if (v > hi_lim) begin
            return VAL_MAX;
        end else if (v < lo_lim) begin
            return VAL_MIN;
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

endpackage

// File: sv/etf_fmul.sv
// Fixed-point multiplier lane: 48x48 magnitude product as two 48x24 partial products.
module etf_fmul
    import etf_pkg::*;
#(
    parameter int FRAC_BITS = 40
)
(
    input  logic                    aclk,
    input  mul_cmd_t                cmd,
    input  logic signed [VAL_W-1:0] x,
    input  logic signed [VAL_W-1:0] y,
    output logic signed [VAL_W-1:0] result
);

    logic [VAL_W-1:0]        x_mag;
    logic [VAL_W-1:0]        y_mag;
    logic                    neg_reg;
    logic [VAL_W+HALF_W-1:0] pp_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic signed [VAL_W-1:0] result_reg;
    logic signed [VAL_W-1:0] result_next;
    logic [PROD_W-1:0]       quot;
    logic [PROD_W-1:0]       bound;

    // Operand magnitudes; the most negative value becomes 2^47
    assign x_mag = x[VAL_W-1] ? VAL_W'(-x) : x;
    assign y_mag = y[VAL_W-1] ? VAL_W'(-y) : y;

    // Scale down, clamp to the signed range, re-apply the sign
    always_comb begin
        quot  = acc_reg >> FRAC_BITS;
        bound = PROD_W'(unsigned'(VAL_MAX)) + PROD_W'(neg_reg);
        if (quot > bound) begin
            result_next = neg_reg ? VAL_MIN : VAL_MAX;
        end else if (neg_reg) begin
            result_next = -$signed(quot[VAL_W-1:0]);
        end else begin
            result_next = $signed(quot[VAL_W-1:0]);
        end
    end

    // Partial products, accumulate, final scaling
    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) begin
            neg_reg <= x[VAL_W-1] ^ y[VAL_W-1];
            pp_reg  <= x_mag * y_mag[HALF_W-1:0];
        end
        if (cmd.mul_hi) begin
            acc_reg <= PROD_W'(pp_reg);
            pp_reg  <= x_mag * y_mag[VAL_W-1:HALF_W];
        end
        if (cmd.mul_acc) begin
            acc_reg <= acc_reg + {pp_reg, {HALF_W{1'b0}}};
        end
        if (cmd.mul_fin) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: sv/etf_sqrt.sv
// Bit-serial integer square root of (sum << FRAC_BITS), clamped to 47 bits.
module etf_sqrt
    import etf_pkg::*;
#(
    parameter int FRAC_BITS = 40
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [VAL_W-1:0] square_sum,
    output logic             busy,
    output logic [MAG_W-1:0] root
);

    localparam int RAD_W  = VAL_W + FRAC_BITS + (FRAC_BITS % 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);
    localparam int EXT_W  = (ROOT_W > MAG_W) ? ROOT_W : MAG_W;

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic [EXT_W-1:0]  root_ext;

    assign busy = (cnt_reg != '0);

    // One root bit per cycle, two radicand bits brought down each step
    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            rad_next  = RAD_W'({square_sum, {FRAC_BITS{1'b0}}});
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
        end else if (busy) begin
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // Clamp to the output range
    assign root_ext = EXT_W'(root_reg);
    assign root     = (root_ext > EXT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

endmodule

// File: sv/etf_datapath.sv
// Datapath: pixel mapping, iteration registers, three multiplier lanes, root unit.
module etf_datapath
    import etf_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int FRAC_BITS    = 40
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  dp_cmd_t            cmd,
    output dp_status_t         sts,
    input  logic [COORD_W-1:0] pixel_col,
    input  logic [COORD_W-1:0] pixel_row,
    output logic [COUNT_W-1:0] escape_count,
    output logic [MAG_W-1:0]   final_magnitude
);

    localparam int DIM_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int DIM_W   = $clog2(DIM_MAX + 1);
    localparam int POS_W   = COORD_W + 1;
    localparam int OFS_W   = ((DIM_W > POS_W) ? DIM_W : POS_W) + 1;
    localparam int MP_W    = MAG_W + 1 + OFS_W;
    localparam int SUM_W   = MP_W + 1;
    localparam int LIM_W   = LIMIT_W + FRAC_BITS;
    localparam int CMP_W   = (LIM_W > VAL_W + 1) ? LIM_W : VAL_W + 1;

    logic signed [OFS_W-1:0]   off_re, off_im;
    logic signed [MP_W-1:0]    prod_re, prod_im;
    logic signed [MP_W-1:0]    map_re_reg, map_im_reg;
    logic signed [SUM_W-1:0]   sum_re, sum_im;
    logic signed [VAL_W-1:0]   pt_re, pt_im;
    logic signed [VAL_W-1:0]   a_reg, b_reg, c_re_reg, c_im_reg;
    logic signed [VAL_W-1:0]   a_next, b_next;
    logic signed [VAL_W-1:0]   sq_a, sq_b, prod_ab;
    logic signed [VAL_W+1:0]   upd_re, upd_im;
    logic [COUNT_W-1:0]        n_reg;
    logic [VAL_W:0]            sq_sum;
    logic [MAG_W-1:0]          root;
    logic [COUNT_W-1:0]        count_reg;
    logic [MAG_W-1:0]          mag_reg;

    // Saturate a mapped coordinate into the value range
    function automatic logic signed [VAL_W-1:0] sat_map(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = {{(SUM_W-VAL_W){1'b0}}, VAL_MAX};
        lo_lim = {{(SUM_W-VAL_W){1'b1}}, VAL_MIN};
        if (v > hi_lim) begin
            return VAL_MAX;
        end else if (v < lo_lim) begin
            return VAL_MIN;
        end else begin
            return v[VAL_W-1:0];
        end
    endfunction

    // Pixel offsets from the image centre, times the scale
    assign off_re  = $signed(OFS_W'({pixel_col, 1'b0})) - $signed(OFS_W'(IMAGE_WIDTH));
    assign off_im  = $signed(OFS_W'({pixel_row, 1'b0})) - $signed(OFS_W'(IMAGE_HEIGHT));
    assign prod_re = $signed({1'b0, cfg.pixel_scale}) * off_re;
    assign prod_im = $signed({1'b0, cfg.pixel_scale}) * off_im;

    // Add the view centre
    assign sum_re = $signed({{(SUM_W-VAL_W){cfg.center_re[VAL_W-1]}}, cfg.center_re})
                  + $signed({map_re_reg[MP_W-1], map_re_reg});
    assign sum_im = $signed({{(SUM_W-VAL_W){cfg.center_im[VAL_W-1]}}, cfg.center_im})
                  + $signed({map_im_reg[MP_W-1], map_im_reg});
    assign pt_re  = sat_map(sum_re);
    assign pt_im  = sat_map(sum_im);

    // Multiplier lanes: a*a, b*b, a*b
    etf_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_aa (
        .aclk(aclk), .cmd(cmd.mul), .x(a_reg), .y(a_reg), .result(sq_a)
    );
    etf_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_bb (
        .aclk(aclk), .cmd(cmd.mul), .x(b_reg), .y(b_reg), .result(sq_b)
    );
    etf_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ab (
        .aclk(aclk), .cmd(cmd.mul), .x(a_reg), .y(b_reg), .result(prod_ab)
    );

    // z = z^2 + c, each part saturated once
    assign upd_re = $signed({{2{sq_a[VAL_W-1]}}, sq_a}) - $signed({{2{sq_b[VAL_W-1]}}, sq_b})
                  + $signed({{2{c_re_reg[VAL_W-1]}}, c_re_reg});
    assign upd_im = $signed({prod_ab[VAL_W-1], prod_ab, 1'b0})
                  + $signed({{2{c_im_reg[VAL_W-1]}}, c_im_reg});
    assign a_next = sat_val(upd_re);
    assign b_next = sat_val(upd_im);

    // Squared magnitude; both squares are non-negative
    assign sq_sum = {1'b0, sq_a} + {1'b0, sq_b};

    assign sts.at_max  = (n_reg >= cfg.max_iterations);
    assign sts.escaped = CMP_W'(sq_sum) > (CMP_W'(cfg.escape_limit) << FRAC_BITS);

    etf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.root_start),
        .square_sum (sq_sum[VAL_W-1:0]),
        .busy       (sts.root_busy),
        .root       (root)
    );

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.map_mul) begin
            map_re_reg <= prod_re;
            map_im_reg <= prod_im;
        end
        if (cmd.map_add) begin
            a_reg    <= pt_re;
            b_reg    <= pt_im;
            c_re_reg <= cfg.fractal_mode ? cfg.julia_re : pt_re;
            c_im_reg <= cfg.fractal_mode ? cfg.julia_im : pt_im;
            n_reg    <= '0;
        end
        if (cmd.update) begin
            a_reg <= a_next;
            b_reg <= b_next;
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.load_out) begin
            count_reg <= (n_reg == cfg.max_iterations) ? '0 : n_reg;
            mag_reg   <= root;
        end
    end

    assign escape_count    = count_reg;
    assign final_magnitude = mag_reg;

    // The count never runs past the maximum
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (n_reg <= cfg.max_iterations))
        else $error("iteration count beyond maximum");

endmodule

// File: sv/etf_ctrl.sv
// Controller: sequences mapping, iteration steps, square root and result hand-off.
module etf_ctrl
    import etf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ACC,
        ST_MUL_FIN,
        ST_CHECK,
        ST_ROOT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   finished;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign finished = sts.at_max || sts.escaped;
    assign out_free = !m_tvalid_reg || m_tready;

    // Commands to the datapath
    always_comb begin
        cmd             = '0;
        cmd.map_mul     = (state_reg == ST_IDLE) && s_tvalid;
        cmd.map_add     = (state_reg == ST_MAP);
        cmd.mul.mul_lo  = (state_reg == ST_MUL_LO);
        cmd.mul.mul_hi  = (state_reg == ST_MUL_HI);
        cmd.mul.mul_acc = (state_reg == ST_MUL_ACC);
        cmd.mul.mul_fin = (state_reg == ST_MUL_FIN);
        cmd.update      = (state_reg == ST_CHECK) && !finished;
        cmd.root_start  = (state_reg == ST_CHECK) && finished;
        cmd.load_out    = (state_reg == ST_OUT) && out_free;
    end

    // Next state and output word valid
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:     state_next = ST_MUL_LO;
            ST_MUL_LO:  state_next = ST_MUL_HI;
            ST_MUL_HI:  state_next = ST_MUL_ACC;
            ST_MUL_ACC: state_next = ST_MUL_FIN;
            ST_MUL_FIN: state_next = ST_CHECK;
            ST_CHECK: begin
                state_next = finished ? ST_ROOT : ST_MUL_LO;
            end
            ST_ROOT: begin
                if (!sts.root_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // One pixel in flight: no second word taken straight after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a pixel is in flight");

    // A new result appears only after a load into the output register
    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cmd.load_out))
        else $error("output valid without a result load");

    // The root unit has finished before the result is loaded
    a_root_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !sts.root_busy)
        else $error("result loaded while square root still running");

endmodule

// File: sv/escape_time_fractal_pixel.sv
// Top level: configuration registers, stream ports, controller and datapath.
// An accepted word: ST_MAP, per iteration ST_MUL_LO, ST_MUL_HI, ST_MUL_ACC, ST_MUL_FIN,
//   ST_CHECK, one more such pass, then ST_ROOT and ST_OUT, whose load raises m_axis_tvalid.
// Default maximum 100 iterations; a pass forms two 48x24 partial products; the root yields
// a bit a cycle, ROOT_W = (48+FRAC_BITS+1)/2 = 44. One pixel at a time, taken in ST_IDLE.
// Synchronous active-low reset restores register defaults and clears the control state.
module escape_time_fractal_pixel
    import etf_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024,
    parameter int FRAC_BITS    = 40
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Pixel input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // pixel_col[9:0], pixel_row[19:10]
    // Result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata   // escape_count[15:0], final_magnitude[62:16]
);

    cfg_t               cfg_reg, cfg_next;
    dp_cmd_t            cmd;
    dp_status_t         sts;
    logic [COUNT_W-1:0] escape_count;
    logic [MAG_W-1:0]   final_magnitude;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FRACTAL_MODE:   cfg_next.fractal_mode   = cfg_data[0];
                CFG_MAX_ITERATIONS: cfg_next.max_iterations = cfg_data[COUNT_W-1:0];
                CFG_ESCAPE_LIMIT:   cfg_next.escape_limit   = cfg_data[LIMIT_W-1:0];
                CFG_CENTER_RE:      cfg_next.center_re      = cfg_data[VAL_W-1:0];
                CFG_CENTER_IM:      cfg_next.center_im      = cfg_data[VAL_W-1:0];
                CFG_PIXEL_SCALE:    cfg_next.pixel_scale    = cfg_data[MAG_W-1:0];
                CFG_JULIA_RE:       cfg_next.julia_re       = cfg_data[VAL_W-1:0];
                CFG_JULIA_IM:       cfg_next.julia_im       = cfg_data[VAL_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    etf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    etf_datapath #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .sts             (sts),
        .pixel_col       (s_axis_tdata[COORD_W-1:0]),
        .pixel_row       (s_axis_tdata[2*COORD_W-1:COORD_W]),
        .escape_count    (escape_count),
        .final_magnitude (final_magnitude)
    );

    // Result word, padded to whole bytes
    assign m_axis_tdata = {{(M_TDATA_W-COUNT_W-MAG_W){1'b0}}, final_magnitude, escape_count};

endmodule

// File: sim/tb_escape_time_fractal_pixel.sv
// Self-checking testbench for the escape-time fractal pixel block, with its own pixel predictor.
`timescale 1ns / 100ps

module tb_escape_time_fractal_pixel;
    import etf_pkg::*;

    localparam int     IMAGE_W     = 1024;
    localparam int     IMAGE_H     = 1024;
    localparam int     FRAC        = 40;
    localparam int     IDLE_LIMIT  = 30000;
    localparam int     TAIL_CYCLES = 700;
    localparam int     RAND_PHASES = 40;
    localparam int     PHASE_ITEMS = 50;
    localparam longint V_MAX       = 64'sd140737488355327;
    localparam longint V_MIN       = -64'sd140737488355328;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [MAG_W-1:0]   magnitude;
    } escape_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // Predictor's copy of the registers
    cfg_t    view_cfg = CFG_RESET;
    pixel_t  pixel_queue[$];
    escape_t escape_queue[$];
    pixel_t  tx_pixel;
    escape_t rx_escape;
    int      pixels_sent    = 0;
    int      pixels_checked = 0;
    int      mismatches     = 0;
    int      tx_gap         = 0;
    int      rx_stall       = 0;
    int      idle_cycles    = 0;
    bit      tx_idle_en     = 1'b1;
    bit      rx_idle_en     = 1'b1;

    escape_time_fractal_pixel #(
        .IMAGE_WIDTH  (IMAGE_W),
        .IMAGE_HEIGHT (IMAGE_H),
        .FRAC_BITS    (FRAC)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // pixel_col[9:0], pixel_row[19:10]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // escape_count[15:0], final_magnitude[62:16]
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_val(input longint v);
        if (v > V_MAX) return V_MAX;
        if (v < V_MIN) return V_MIN;
        return v;
    endfunction

    // Fixed-point product: magnitudes multiplied, truncated, sign restored, clamped
    function automatic longint fx_mul(input longint x, input longint y);
        bit           neg;
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] q;
        neg = (x < 0) != (y < 0);
        ma  = (x < 0) ? -x : x;
        mb  = (y < 0) ? -y : y;
        q   = (ma * mb) >> FRAC;
        if (neg) begin
            if (q > (128'd1 << 47)) return V_MIN;
            return -longint'(q[63:0]);
        end
        if (q > 128'(V_MAX)) return V_MAX;
        return longint'(q[63:0]);
    endfunction

    // floor(sqrt(sum << FRAC)), clamped to the magnitude width
    function automatic logic [MAG_W-1:0] root_of_sum(input longint sum);
        logic [127:0] target;
        logic [127:0] root;
        logic [127:0] trial;
        target = 128'(sum) << FRAC;
        root   = '0;
        for (int k = 62; k >= 0; k--) begin
            trial = root | (128'd1 << k);
            if (trial * trial <= target) root = trial;
        end
        if (root > 128'(MAG_MAX)) return MAG_MAX;
        return root[MAG_W-1:0];
    endfunction

    function automatic longint map_axis(input logic [COORD_W-1:0] pos,
                                        input logic signed [VAL_W-1:0] centre, input int size);
        longint d;
        d = 2 * longint'(pos) - size;
        return clamp_val(longint'(centre) + longint'(view_cfg.pixel_scale) * d);
    endfunction

    function automatic escape_t predict_escape(input pixel_t px);
        escape_t     res;
        longint      a, b, c_re, c_im, sa, sb, ab, na, sum;
        logic [63:0] lim;
        int          n;
        a    = map_axis(px.col, view_cfg.center_re, IMAGE_W);
        b    = map_axis(px.row, view_cfg.center_im, IMAGE_H);
        c_re = a;
        c_im = b;
        if (view_cfg.fractal_mode) begin
            c_re = longint'($signed(view_cfg.julia_re));
            c_im = longint'($signed(view_cfg.julia_im));
        end
        lim = 64'(view_cfg.escape_limit) << FRAC;
        n   = 0;
        forever begin
            sa  = fx_mul(a, a);
            sb  = fx_mul(b, b);
            sum = sa + sb;
            if (n >= int'(view_cfg.max_iterations) || 64'(sum) > lim) break;
            ab = fx_mul(a, b);
            na = clamp_val(sa - sb + c_re);
            b  = clamp_val(2 * ab + c_im);
            a  = na;
            n++;
        end
        res.count     = (n == int'(view_cfg.max_iterations)) ? '0 : COUNT_W'(n);
        res.magnitude = root_of_sum(sum);
        return res;
    endfunction

    // ---------------------------------------------------------------- helpers

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 200) $display("%0t ns mismatch: %s", $realtime, what);
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // Random signed value spread over about +/- 2^(63-shift)
    function automatic logic [47:0] rand_fixed(input int shift);
        longint r;
        r = {$urandom, $urandom};
        r = r >>> shift;
        return r[47:0];
    endfunction

    // One register write; called right after a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_FRACTAL_MODE:   view_cfg.fractal_mode   = value[0];
            CFG_MAX_ITERATIONS: view_cfg.max_iterations = value[COUNT_W-1:0];
            CFG_ESCAPE_LIMIT:   view_cfg.escape_limit   = value[LIMIT_W-1:0];
            CFG_CENTER_RE:      view_cfg.center_re      = value;
            CFG_CENTER_IM:      view_cfg.center_im      = value;
            CFG_PIXEL_SCALE:    view_cfg.pixel_scale    = value[MAG_W-1:0];
            CFG_JULIA_RE:       view_cfg.julia_re       = value;
            CFG_JULIA_IM:       view_cfg.julia_im       = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Rewrite every register; junk fills the unused upper bits of the narrow ones
    task automatic set_view(input bit mode, input logic [COUNT_W-1:0] max_it,
                            input logic [LIMIT_W-1:0] lim, input logic [47:0] c_re,
                            input logic [47:0] c_im, input logic [MAG_W-1:0] scale,
                            input logic [47:0] j_re, input logic [47:0] j_im, input bit junk);
        logic [47:0] hi;
        hi = junk ? rand48() : '0;
        @(posedge aclk);
        write_reg(CFG_FRACTAL_MODE,   {hi[47:1], mode});
        write_reg(CFG_MAX_ITERATIONS, {hi[47:COUNT_W], max_it});
        write_reg(CFG_ESCAPE_LIMIT,   {hi[47:LIMIT_W], lim});
        write_reg(CFG_CENTER_RE,      c_re);
        write_reg(CFG_CENTER_IM,      c_im);
        write_reg(CFG_PIXEL_SCALE,    {hi[47], scale});
        write_reg(CFG_JULIA_RE,       j_re);
        write_reg(CFG_JULIA_IM,       j_im);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_pixel(input int col, input int row);
        pixel_t px;
        px.col = COORD_W'(col);
        px.row = COORD_W'(row);
        pixel_queue.insert(pixel_queue.size(), px);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        wait (pixels_checked == pixels_sent);
    endtask

    // ---------------------------------------------------------------- pixel driver

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            // word taken at this edge: predict it with the registers now in force
            if (s_axis_tvalid) begin
                tx_pixel.col = s_axis_tdata[COORD_W-1:0];
                tx_pixel.row = s_axis_tdata[2*COORD_W-1:COORD_W];
                escape_queue.insert(escape_queue.size(), predict_escape(tx_pixel));
            end
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                tx_pixel = pixel_queue.pop_front();
                s_axis_tdata  <= {{(S_TDATA_W - 2*COORD_W){1'b0}}, tx_pixel.row, tx_pixel.col};
                s_axis_tvalid <= 1'b1;
                tx_gap = tx_idle_en ? $urandom_range(0, 4) : 0;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- result monitor

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (escape_queue.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
                end else begin
                    rx_escape = escape_queue.pop_front();
                    if (m_axis_tdata[COUNT_W-1:0] !== rx_escape.count)
                        report_mismatch($sformatf("escape_count %0d, expected %0d",
                            m_axis_tdata[COUNT_W-1:0], rx_escape.count));
                    if (m_axis_tdata[COUNT_W+MAG_W-1:COUNT_W] !== rx_escape.magnitude)
                        report_mismatch($sformatf("final_magnitude %h, expected %h",
                            m_axis_tdata[COUNT_W+MAG_W-1:COUNT_W], rx_escape.magnitude));
                end
                pixels_checked++;
                rx_stall = rx_idle_en ? $urandom_range(0, 4) : 0;
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_axis_tready <= (rx_stall == 0);
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAIL escape_time_fractal_pixel");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        logic [47:0]      c_re, c_im, j_re, j_im;
        logic [MAG_W-1:0] scale;
        logic [63:0]      r;
        logic [15:0]      max_it;
        logic [6:0]       lim;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset view: corners, centre point (bounded, runs to the maximum)
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(512, 512);
        queue_pixel(0, 1023);
        queue_pixel(1023, 0);
        wait_drained();

        // Zero maximum with zero escape limit: loop never runs
        set_view(1'b0, 16'd0, 7'd0, 48'd0, 48'd0, 47'd1099511628, 48'd0, 48'd0, 1'b0);
        queue_pixel(100, 200);
        queue_pixel(1023, 1023);
        wait_drained();

        // Zero escape limit: anything away from the origin escapes at once
        set_view(1'b0, 16'd10, 7'd0, 48'd0, 48'd0, 47'd1099511628, 48'd0, 48'd0, 1'b0);
        queue_pixel(512, 512);
        queue_pixel(0, 0);
        wait_drained();

        // Extremes everywhere: mapping and squares saturate, Julia mode
        set_view(1'b1, 16'hFFFF, 7'd127, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, MAG_MAX,
                 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b0);
        queue_pixel(0, 0);
        queue_pixel(1023, 1023);
        queue_pixel(1023, 0);
        queue_pixel(512, 512);
        wait_drained();

        // Zero scale: pixel lands on the centre; origin never escapes
        set_view(1'b0, 16'd1000, 7'd4, 48'd0, 48'd0, 47'd0, 48'd0, 48'd0, 1'b0);
        queue_pixel(5, 900);
        wait_drained();

        // Zero scale just outside the cusp: slow escape, large count
        set_view(1'b0, 16'd1000, 7'd4, 48'd285873023221, 48'd0, 47'd0, 48'd0, 48'd0, 1'b0);
        queue_pixel(777, 3);
        wait_drained();

        // Largest maximum with escaping corners, wide escape limit
        set_view(1'b0, 16'hFFFF, 7'd64, 48'hFF80_0000_0000, 48'd0, 47'd1099511628,
                 48'd0, 48'd0, 1'b1);
        queue_pixel(0, 0);
        queue_pixel(1023, 0);
        queue_pixel(1023, 1023);
        wait_drained();

        // Julia set around a classic constant
        set_view(1'b1, 16'd200, 7'd4, 48'd0, 48'd0, 47'd1610612736,
                 -48'sd879609302221, 48'd171523813933, 1'b0);
        queue_pixel(512, 512);
        queue_pixel(300, 700);
        queue_pixel(0, 0);
        wait_drained();

        // Random views, random pixels
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            max_it = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 48));
            lim    = ($urandom_range(0, 1) == 0) ? 7'd4 : 7'($urandom_range(0, 127));
            c_re   = ($urandom_range(0, 9) == 0) ? rand_fixed(16) : rand_fixed(22);
            c_im   = ($urandom_range(0, 9) == 0) ? rand_fixed(16) : rand_fixed(23);
            r      = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0)
                scale = r[MAG_W-1:0];
            else
                scale = MAG_W'(r >> (31 + $urandom_range(0, 12)));
            j_re   = ($urandom_range(0, 9) == 0) ? rand_fixed(16) : rand_fixed(23);
            j_im   = ($urandom_range(0, 9) == 0) ? rand_fixed(16) : rand_fixed(23);
            set_view(1'($urandom_range(0, 1)), max_it, lim, c_re, c_im, scale, j_re, j_im,
                     1'($urandom_range(0, 1)));
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
            wait_drained();
        end

        // Let any stray result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (escape_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", escape_queue.size()));
        if (mismatches == 0)
            $display("PASS escape_time_fractal_pixel");
        else
            $display("FAIL escape_time_fractal_pixel");
        $finish;
    end

endmodule
